// ===== hw/rtl/tmm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmm_pkg
// Shared constants, codes and types of the tiny memory machine step block.
// ----------------------------------------------------------------------------
package tmm_pkg;

  localparam int MEM_DEPTH  = 256;
  localparam int PROG_DEPTH = 1024;

  localparam int ADDR_W = $clog2(MEM_DEPTH);
  localparam int PC_W   = $clog2(PROG_DEPTH);
  localparam int IDX_W  = PC_W + 1;
  localparam int DATA_W = 32;
  localparam int OPC_W  = 5;
  localparam int P0_W   = 10;
  localparam int P1_W   = 8;
  localparam int P2_W   = 8;
  localparam int P3_W   = 10;
  localparam int PLEN_W = 11;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // register index, taken from paddr[2]
  localparam logic REG_PROGRAM_LENGTH = 1'b0;

  // action codes
  localparam logic ACT_EXEC = 1'b0;
  localparam logic ACT_LOAD = 1'b1;

  // opcodes
  localparam logic [OPC_W-1:0] OP_MOVE  = 5'd1;
  localparam logic [OPC_W-1:0] OP_ADD   = 5'd3;
  localparam logic [OPC_W-1:0] OP_SUB   = 5'd4;
  localparam logic [OPC_W-1:0] OP_JUMP  = 5'd6;
  localparam logic [OPC_W-1:0] OP_IF    = 5'd7;
  localparam logic [OPC_W-1:0] OP_PRINT = 5'd13;
  localparam logic [OPC_W-1:0] OP_READ  = 5'd14;

  // compare codes for if
  localparam logic [P2_W-1:0] CMP_EQ = 8'd8;
  localparam logic [P2_W-1:0] CMP_LT = 8'd9;
  localparam logic [P2_W-1:0] CMP_GT = 8'd10;
  localparam logic [P2_W-1:0] CMP_LE = 8'd11;
  localparam logic [P2_W-1:0] CMP_GE = 8'd12;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
  } mem_rd_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } mem_wr_t;

endpackage

// ===== hw/rtl/tmm_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmm_if
// Valid/ready channels for instruction words in and result words out.
// ----------------------------------------------------------------------------
interface tmm_in_if import tmm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic [OPC_W-1:0]         opcode;
  logic [P0_W-1:0]          param_zero;
  logic [P1_W-1:0]          param_one;
  logic [P2_W-1:0]          param_two;
  logic [P3_W-1:0]          param_three;
  logic signed [DATA_W-1:0] data_value;

  modport source (
    output valid, action, opcode, param_zero, param_one, param_two, param_three,
           data_value,
    input  ready
  );
  modport sink (
    input  valid, action, opcode, param_zero, param_one, param_two, param_three,
           data_value,
    output ready
  );
endinterface

interface tmm_out_if import tmm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [PC_W-1:0]          next_index;
  logic                     print_valid;
  logic signed [DATA_W-1:0] print_value;
  logic                     done_res;

  modport source (
    output valid, next_index, print_valid, print_value, done_res,
    input  ready
  );
  modport sink (
    input  valid, next_index, print_valid, print_value, done_res,
    output ready
  );
endinterface

// ===== hw/rtl/tmm_dmem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmm_dmem
// Data memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module tmm_dmem import tmm_pkg::*; (
  input  logic              clk,
  input  mem_rd_t           rd_req,
  input  mem_wr_t           wr_req,
  output logic [DATA_W-1:0] rd_a,
  output logic [DATA_W-1:0] rd_b
);

  logic [DATA_W-1:0] mem [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_req.en) begin
      mem[wr_req.addr] <= wr_req.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_req.en) begin
      rd_a <= mem[rd_req.addr_a];
      rd_b <= mem[rd_req.addr_b];
    end
  end

endmodule

// ===== hw/rtl/tmm_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmm_cfg
// APB register slave holding the program length.
// ----------------------------------------------------------------------------
module tmm_cfg import tmm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [PLEN_W-1:0]  program_length
);

  logic [PLEN_W-1:0] plen_r;
  logic              wr_plen;

  assign pready  = 1'b1;
  assign wr_plen = psel && penable && pwrite && (paddr[2] == REG_PROGRAM_LENGTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r <= '0;
    end else if (wr_plen) begin
      plen_r <= pwdata[PLEN_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_PROGRAM_LENGTH) begin
      prdata = {{(PDATA_W-PLEN_W){1'b0}}, plen_r};
    end
  end

  assign program_length = plen_r;

endmodule

// ===== hw/rtl/tmm_exec.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmm_exec
// Execute stage: operand bypass, alu, compare, next index and result register.
// ----------------------------------------------------------------------------
module tmm_exec import tmm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  tmm_in_if.sink            in_word,
  tmm_out_if.source         out_word,
  input  logic [PLEN_W-1:0] program_length,
  output mem_rd_t           rd_req,
  output mem_wr_t           wr_req,
  input  logic [DATA_W-1:0] rd_a,
  input  logic [DATA_W-1:0] rd_b
);

  // execute stage registers
  logic              s1_v_r;
  logic              s1_action_r;
  logic [OPC_W-1:0]  s1_opcode_r;
  logic [P0_W-1:0]   s1_p0_r;
  logic [P2_W-1:0]   s1_p2_r;
  logic [P3_W-1:0]   s1_p3_r;
  logic [DATA_W-1:0] s1_dv_r;
  logic              s1_byp_a_r;
  logic              s1_byp_b_r;
  logic [DATA_W-1:0] s1_byp_data_r;

  logic [IDX_W-1:0]  idx_r;
  logic [IDX_W-1:0]  idx_nxt;

  // result register
  logic              out_v_r;
  logic [PC_W-1:0]   out_next_r;
  logic              out_pv_r;
  logic [DATA_W-1:0] out_pval_r;
  logic              out_done_r;

  logic              out_free;
  logic              s1_go;
  logic              in_fire;
  logic              in_is_if;
  logic              in_is_print;
  logic [DATA_W-1:0] opa;
  logic [DATA_W-1:0] opb;
  logic              run;
  logic              wen;
  logic [DATA_W-1:0] wdata;
  logic              holds;
  logic              take_branch;
  logic [PC_W-1:0]   tgt_src;
  logic [IDX_W-1:0]  tgt;
  logic [IDX_W-1:0]  inc;
  logic              pv;

  assign out_free      = !out_v_r || out_word.ready;
  assign s1_go         = s1_v_r && out_free;
  assign in_word.ready = !s1_v_r || out_free;
  assign in_fire       = in_word.valid && in_word.ready;

  // read address select for the incoming word
  assign in_is_if    = (in_word.opcode == OP_IF);
  assign in_is_print = (in_word.opcode == OP_PRINT);

  always_comb begin
    rd_req.en     = in_fire;
    rd_req.addr_a = (in_is_if || in_is_print) ? in_word.param_zero[ADDR_W-1:0]
                                              : in_word.param_one[ADDR_W-1:0];
    rd_req.addr_b = in_is_if ? in_word.param_one[ADDR_W-1:0]
                             : in_word.param_two[ADDR_W-1:0];
  end

  // operands with bypass of the write made when this word was read
  assign opa = s1_byp_a_r ? s1_byp_data_r : rd_a;
  assign opb = s1_byp_b_r ? s1_byp_data_r : rd_b;

  assign run = (s1_action_r == ACT_EXEC) && (idx_r < program_length);

  always_comb begin
    unique case (s1_p2_r)
      CMP_EQ:  holds = (opa == opb);
      CMP_LT:  holds = ($signed(opa) <  $signed(opb));
      CMP_GT:  holds = ($signed(opa) >  $signed(opb));
      CMP_LE:  holds = ($signed(opa) <= $signed(opb));
      CMP_GE:  holds = ($signed(opa) >= $signed(opb));
      default: holds = 1'b0;
    endcase
  end

  always_comb begin
    wen         = 1'b0;
    wdata       = s1_dv_r;
    take_branch = 1'b0;
    tgt_src     = s1_p0_r;
    pv          = 1'b0;
    if (s1_action_r == ACT_LOAD) begin
      wen = 1'b1;
    end else if (run) begin
      unique case (s1_opcode_r)
        OP_READ: begin
          wen = 1'b1;
        end
        OP_MOVE: begin
          wen   = 1'b1;
          wdata = opa;
        end
        OP_ADD: begin
          wen   = 1'b1;
          wdata = opa + opb;
        end
        OP_SUB: begin
          wen   = 1'b1;
          wdata = opa - opb;
        end
        OP_PRINT: begin
          pv = 1'b1;
        end
        OP_IF: begin
          take_branch = !holds;
          tgt_src     = s1_p3_r;
        end
        OP_JUMP: begin
          take_branch = 1'b1;
        end
        default: begin
          wen = 1'b0;
        end
      endcase
    end
  end

  // target minus one wraps within the program space
  assign tgt = {1'b0, tgt_src - 1'b1};
  assign inc = idx_r + 1'b1;

  always_comb begin
    idx_nxt = idx_r;
    if (run) begin
      if (take_branch) begin
        idx_nxt = tgt;
      end else if (inc > IDX_W'(PROG_DEPTH)) begin
        idx_nxt = IDX_W'(PROG_DEPTH);
      end else begin
        idx_nxt = inc;
      end
    end
  end

  always_comb begin
    wr_req.en   = s1_go && wen;
    wr_req.addr = s1_p0_r[ADDR_W-1:0];
    wr_req.data = wdata;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (in_fire) begin
        s1_v_r <= 1'b1;
      end else if (s1_go) begin
        s1_v_r <= 1'b0;
      end
      if (s1_go) begin
        out_v_r <= 1'b1;
        idx_r   <= idx_nxt;
      end else if (out_word.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_action_r   <= in_word.action;
      s1_opcode_r   <= in_word.opcode;
      s1_p0_r       <= in_word.param_zero;
      s1_p2_r       <= in_word.param_two;
      s1_p3_r       <= in_word.param_three;
      s1_dv_r       <= in_word.data_value;
      s1_byp_a_r    <= wr_req.en && (wr_req.addr == rd_req.addr_a);
      s1_byp_b_r    <= wr_req.en && (wr_req.addr == rd_req.addr_b);
      s1_byp_data_r <= wr_req.data;
    end
    if (s1_go) begin
      out_next_r <= idx_nxt[PC_W-1:0];
      out_pv_r   <= pv;
      out_pval_r <= pv ? opa : '0;
      out_done_r <= (idx_nxt >= program_length);
    end
  end

  assign out_word.valid       = out_v_r;
  assign out_word.next_index  = out_next_r;
  assign out_word.print_valid = out_pv_r;
  assign out_word.print_value = out_pval_r;
  assign out_word.done_res    = out_done_r;

endmodule

// ===== hw/rtl/tiny_memory_machine_step_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiny_memory_machine_step_top
// Steps a small memory-to-memory machine, one instruction or load per word.
//
// in_word carries one instruction (or a data memory load) per word and
// out_word returns exactly one result word for each: next index, print flag
// and value, and the done flag. Both use valid/ready; a word moves when both
// are high. The program length is written over the APB port (psel..pready);
// the user must write it only while the block is idle, which the block does
// not enforce itself; pready is always high. The data memory read is
// registered at the same edge as the word is accepted, and the execute stage
// loads the output register once that register is free. Throughput is one
// word per cycle while out_word is not stalled; a write made by one word is
// bypassed to the operands of the word right behind it.
// When out_word stalls, one more word is taken into the execute stage,
// then in_word.ready drops until the result register drains.
// Reset clears the instruction index, the program length and the pipeline
// valids; data memory holds no defined value until it is written.
// ----------------------------------------------------------------------------
module tiny_memory_machine_step_top import tmm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  tmm_in_if.sink             in_word,
  tmm_out_if.source          out_word,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [PLEN_W-1:0] program_length;
  mem_rd_t           rd_req;
  mem_wr_t           wr_req;
  logic [DATA_W-1:0] rd_a;
  logic [DATA_W-1:0] rd_b;

  tmm_cfg u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .program_length (program_length)
  );

  tmm_dmem u_dmem (
    .clk    (clk),
    .rd_req (rd_req),
    .wr_req (wr_req),
    .rd_a   (rd_a),
    .rd_b   (rd_b)
  );

  tmm_exec u_exec (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_word        (in_word),
    .out_word       (out_word),
    .program_length (program_length),
    .rd_req         (rd_req),
    .wr_req         (wr_req),
    .rd_a           (rd_a),
    .rd_b           (rd_b)
  );

endmodule

// ===== tb/tb_tiny_memory_machine_step_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tiny_memory_machine_step_top
// Self-checking bench for the tiny memory machine step block.
//
// Words go in over a valid/ready channel with random bursts and gaps, and
// results come back through a receiver that stalls on its own pattern. Every
// word sent runs through a local machine model (data memory, index, program
// length) and its expected result is queued. A monitor compares each result
// word, field by field, against the oldest expectation. Directed words cover
// the field extremes, every opcode and compare code, address and target
// wrap, the done state and running off the end of the program. Random phases
// then run short programs of mixed words under several program lengths.
// Source addresses are always steered to data words already written.
// ----------------------------------------------------------------------------
module tb_tiny_memory_machine_step_top;
  import tmm_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned SETTLE_CYCLES   = 6;
  localparam int unsigned HOLD_OFF_CYCLES = 80;
  localparam int unsigned RANDOM_PHASES   = 18;
  localparam int unsigned PHASE_WORDS     = 100;

  // opcodes and compare codes that the block treats as unknown
  localparam logic [OPC_W-1:0] OP_NONE_LOW  = 5'd0;
  localparam logic [OPC_W-1:0] OP_NONE_HIGH = 5'd31;
  localparam logic [P2_W-1:0]  CMP_BAD_ZERO = 8'd0;
  localparam logic [P2_W-1:0]  CMP_BAD_NEXT = 8'd13;

  typedef struct packed {
    logic              action;
    logic [OPC_W-1:0]  opcode;
    logic [P0_W-1:0]   param_zero;
    logic [P1_W-1:0]   param_one;
    logic [P2_W-1:0]   param_two;
    logic [P3_W-1:0]   param_three;
    logic [DATA_W-1:0] data_value;
  } instr_word_t;

  typedef struct packed {
    logic [PC_W-1:0]   next_index;
    logic              print_valid;
    logic [DATA_W-1:0] print_value;
    logic              done_res;
  } step_result_t;

  logic               clk;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  tmm_in_if  in_word_if ();
  tmm_out_if out_word_if ();

  tiny_memory_machine_step_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word_if),
    .out_word (out_word_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // machine model
  logic [DATA_W-1:0] mem_model [MEM_DEPTH];
  bit                written_map [MEM_DEPTH];
  logic [ADDR_W-1:0] written_list [$];
  logic [IDX_W-1:0]  idx_model;
  logic [PLEN_W-1:0] plen_model;

  step_result_t expected_results [$];
  int unsigned  error_count;
  int unsigned  cycle_count;
  int unsigned  burst_left;
  bit           no_gaps;
  bit           hold_off_req;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic void write_data(input logic [ADDR_W-1:0] addr,
                                     input logic [DATA_W-1:0] value);
    mem_model[addr] = value;
    if (!written_map[addr]) begin
      written_map[addr] = 1'b1;
      written_list.push_back(addr);
    end
  endfunction

  function automatic step_result_t step_machine(input instr_word_t w);
    step_result_t      r;
    logic [IDX_W-1:0]  nxt;
    logic [ADDR_W-1:0] a0;
    logic [ADDR_W-1:0] a1;
    logic [ADDR_W-1:0] a2;
    logic [DATA_W-1:0] va;
    logic [DATA_W-1:0] vb;
    logic              holds;
    a0 = w.param_zero[ADDR_W-1:0];
    a1 = w.param_one[ADDR_W-1:0];
    a2 = w.param_two[ADDR_W-1:0];
    r = '0;
    if (w.action == ACT_LOAD) begin
      write_data(a0, w.data_value);
    end else if (idx_model < plen_model) begin
      nxt = idx_model + 1'b1;
      case (w.opcode)
        OP_READ:  write_data(a0, w.data_value);
        OP_MOVE:  write_data(a0, mem_model[a1]);
        OP_ADD:   write_data(a0, mem_model[a1] + mem_model[a2]);
        OP_SUB:   write_data(a0, mem_model[a1] - mem_model[a2]);
        OP_PRINT: begin
          r.print_valid = 1'b1;
          r.print_value = mem_model[a0];
        end
        OP_IF: begin
          va = mem_model[a0];
          vb = mem_model[a1];
          case (w.param_two)
            CMP_EQ:  holds = (va == vb);
            CMP_LT:  holds = ($signed(va) <  $signed(vb));
            CMP_GT:  holds = ($signed(va) >  $signed(vb));
            CMP_LE:  holds = ($signed(va) <= $signed(vb));
            CMP_GE:  holds = ($signed(va) >= $signed(vb));
            default: holds = 1'b0;
          endcase
          if (!holds) nxt = {1'b0, w.param_three - 1'b1};
        end
        OP_JUMP:  nxt = {1'b0, w.param_zero - 1'b1};
        default: ;
      endcase
      if (nxt > PROG_DEPTH) nxt = IDX_W'(PROG_DEPTH);
      idx_model = nxt;
    end
    r.next_index = idx_model[PC_W-1:0];
    r.done_res   = (idx_model >= plen_model);
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [DATA_W-1:0] want,
                                      input logic [DATA_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    step_result_t want;
    if (rst_n && out_word_if.valid && out_word_if.ready) begin
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected: next_index %0d",
               out_word_if.next_index);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("next_index", DATA_W'(want.next_index),
                    DATA_W'(out_word_if.next_index));
        check_field("print_valid", DATA_W'(want.print_valid),
                    DATA_W'(out_word_if.print_valid));
        check_field("print_value", want.print_value, out_word_if.print_value);
        check_field("done_res", DATA_W'(want.done_res), DATA_W'(out_word_if.done_res));
      end
    end
  end

  // receiver: random modes, plus a long hold-off on request
  initial begin : receiver
    int unsigned mode;
    int unsigned mode_left;
    int unsigned hold_left;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    out_word_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_word_if.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          0: out_word_if.ready <= 1'b1;
          1: out_word_if.ready <= ($urandom_range(0, 9) < 7);
          2: out_word_if.ready <= ($urandom_range(0, 9) < 3);
          default: out_word_if.ready <= !out_word_if.ready;
        endcase
      end
    end
  end

  task automatic send_word(input instr_word_t w);
    int unsigned gap;
    if (!no_gaps && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      in_word_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 20);
    end
    if (burst_left > 0) burst_left--;
    expected_results.push_back(step_machine(w));
    in_word_if.valid       <= 1'b1;
    in_word_if.action      <= w.action;
    in_word_if.opcode      <= w.opcode;
    in_word_if.param_zero  <= w.param_zero;
    in_word_if.param_one   <= w.param_one;
    in_word_if.param_two   <= w.param_two;
    in_word_if.param_three <= w.param_three;
    in_word_if.data_value  <= w.data_value;
    @(posedge clk);
    while (!in_word_if.ready) @(posedge clk);
  endtask

  task automatic wait_idle(input int unsigned settle);
    in_word_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_plen(input int unsigned value);
    wait_idle(SETTLE_CYCLES);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_PROGRAM_LENGTH, 2'b00};
    pwdata  <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    plen_model = PLEN_W'(value);
  endtask

  function automatic instr_word_t make_word(input logic a, input logic [OPC_W-1:0] op,
                                            input logic [P0_W-1:0] p0,
                                            input logic [P1_W-1:0] p1,
                                            input logic [P2_W-1:0] p2,
                                            input logic [P3_W-1:0] p3,
                                            input logic [DATA_W-1:0] dv);
    instr_word_t w;
    w.action      = a;
    w.opcode      = op;
    w.param_zero  = p0;
    w.param_one   = p1;
    w.param_two   = p2;
    w.param_three = p3;
    w.data_value  = dv;
    return w;
  endfunction

  function automatic logic [ADDR_W-1:0] pick_src(input logic [ADDR_W-1:0] want);
    if (written_map[want]) return want;
    return written_list[$urandom_range(0, written_list.size() - 1)];
  endfunction

  function automatic logic [P0_W-1:0] pick_target();
    if (plen_model > 0 && $urandom_range(0, 99) < 85)
      return P0_W'($urandom_range(1, plen_model));
    return P0_W'($urandom);
  endfunction

  function automatic int unsigned choose_plen();
    int unsigned len;
    len = idx_model + 1 + $urandom_range(0, 40);
    case ($urandom_range(0, 9))
      0: return 0;
      1: return PROG_DEPTH;
      2: return $urandom_range(0, PROG_DEPTH);
      default: return (len > PROG_DEPTH) ? PROG_DEPTH : len;
    endcase
  endfunction

  function automatic instr_word_t gen_random_word();
    instr_word_t w;
    int unsigned sel;
    w.action      = ACT_EXEC;
    w.opcode      = OPC_W'($urandom);
    w.param_zero  = P0_W'($urandom);
    w.param_one   = P1_W'($urandom);
    w.param_two   = P2_W'($urandom);
    w.param_three = P3_W'($urandom);
    w.data_value  = $urandom;
    if ($urandom_range(0, 99) < 30) begin
      case ($urandom_range(0, 4))
        0: w.data_value = '0;
        1: w.data_value = '1;
        2: w.data_value = 32'h7FFF_FFFF;
        3: w.data_value = 32'h8000_0000;
        default: w.data_value = DATA_W'($urandom_range(0, 3));
      endcase
    end
    sel = $urandom_range(0, 99);
    if (sel < 12) w.action = ACT_LOAD;
    else if (sel < 22) w.opcode = OP_READ;
    else if (sel < 32) w.opcode = OP_MOVE;
    else if (sel < 44) w.opcode = OP_ADD;
    else if (sel < 56) w.opcode = OP_SUB;
    else if (sel < 64) w.opcode = OP_PRINT;
    else if (sel < 72) begin
      w.opcode     = OP_JUMP;
      w.param_zero = pick_target();
    end else if (sel < 86) begin
      w.opcode      = OP_IF;
      w.param_three = pick_target();
      if ($urandom_range(0, 99) < 85) w.param_two = CMP_EQ + P2_W'($urandom_range(0, 4));
    end else if (sel < 93) begin
      case (w.opcode)
        OP_MOVE, OP_ADD, OP_SUB, OP_JUMP, OP_IF, OP_PRINT, OP_READ: w.opcode = OP_NONE_HIGH;
        default: ;
      endcase
    end else begin
      w.action = 1'($urandom_range(0, 1));
    end
    // steer every source read to a data word already written
    if (w.action == ACT_EXEC) begin
      case (w.opcode)
        OP_MOVE: w.param_one = pick_src(w.param_one);
        OP_ADD, OP_SUB: begin
          w.param_one = pick_src(w.param_one);
          w.param_two = pick_src(w.param_two);
        end
        OP_PRINT: w.param_zero[ADDR_W-1:0] = pick_src(w.param_zero[ADDR_W-1:0]);
        OP_IF: begin
          w.param_zero[ADDR_W-1:0] = pick_src(w.param_zero[ADDR_W-1:0]);
          w.param_one = pick_src(w.param_one);
        end
        default: ;
      endcase
    end
    // keep the index off the end until the last test
    if (w.action == ACT_EXEC && plen_model == PROG_DEPTH && idx_model == PROG_DEPTH - 1)
      w.opcode = OP_JUMP;
    return w;
  endfunction

  task automatic test_already_done();
    send_word(make_word(ACT_EXEC, OP_READ, 10'd9, 8'd0, 8'd0, 10'd0, 32'd5));
    send_word(make_word(ACT_LOAD, OP_NONE_LOW, 10'd0, 8'd0, 8'd0, 10'd0, 32'h7FFF_FFFF));
  endtask

  task automatic test_load_and_arith();
    write_plen(PROG_DEPTH);
    send_word(make_word(ACT_LOAD, OP_READ, 10'd1023, 8'd0, 8'd0, 10'd0, 32'h8000_0000));
    send_word(make_word(ACT_LOAD, OP_MOVE, 10'd257, 8'd0, 8'd0, 10'd0, 32'hFFFF_FFFF));
    send_word(make_word(ACT_EXEC, OP_READ, 10'd2, 8'd0, 8'd0, 10'd0, 32'd1));
    send_word(make_word(ACT_EXEC, OP_MOVE, 10'd3, 8'd255, 8'd0, 10'd0, 32'd0));
    send_word(make_word(ACT_EXEC, OP_ADD, 10'd4, 8'd0, 8'd0, 10'd0, 32'd0));
    send_word(make_word(ACT_EXEC, OP_ADD, 10'd6, 8'd0, 8'd2, 10'd0, 32'd0));
    send_word(make_word(ACT_EXEC, OP_SUB, 10'd5, 8'd255, 8'd2, 10'd0, 32'd0));
    send_word(make_word(ACT_EXEC, OP_PRINT, 10'd4, 8'd0, 8'd0, 10'd0, 32'd0));
    send_word(make_word(ACT_EXEC, OP_PRINT, 10'd1023, 8'd0, 8'd0, 10'd0, 32'd0));
    send_word(make_word(ACT_EXEC, OP_NONE_HIGH, 10'd1023, 8'd255, 8'd255, 10'd1023,
                        32'hFFFF_FFFF));
    send_word(make_word(ACT_EXEC, OP_NONE_LOW, 10'd0, 8'd0, 8'd0, 10'd0, 32'd0));
  endtask

  task automatic test_branches();
    send_word(make_word(ACT_EXEC, OP_IF, 10'd0, 8'd255, CMP_EQ, 10'd20, 32'd0));
    send_word(make_word(ACT_EXEC, OP_IF, 10'd255, 8'd0, CMP_LT, 10'd500, 32'd0));
    send_word(make_word(ACT_EXEC, OP_IF, 10'd255, 8'd0, CMP_GT, 10'd0, 32'd0));
    send_word(make_word(ACT_EXEC, OP_JUMP, 10'd1, 8'd0, 8'd0, 10'd0, 32'd0));
    send_word(make_word(ACT_EXEC, OP_IF, 10'd1, 8'd1, CMP_LE, 10'd7, 32'd0));
    send_word(make_word(ACT_EXEC, OP_IF, 10'd255, 8'd0, CMP_GE, 10'd1000, 32'd0));
    send_word(make_word(ACT_EXEC, OP_IF, 10'd0, 8'd1, CMP_BAD_NEXT, 10'd5, 32'd0));
    send_word(make_word(ACT_EXEC, OP_IF, 10'd0, 8'd0, CMP_BAD_ZERO, 10'd1023, 32'd0));
    send_word(make_word(ACT_EXEC, OP_JUMP, 10'd0, 8'd0, 8'd0, 10'd0, 32'd0));
    send_word(make_word(ACT_EXEC, OP_JUMP, 10'd10, 8'd0, 8'd0, 10'd0, 32'd0));
    send_word(make_word(ACT_EXEC, OP_IF, 10'd0, 8'd255, CMP_GT, 10'd40, 32'd0));
    send_word(make_word(ACT_EXEC, OP_IF, 10'd1, 8'd1, CMP_GE, 10'd40, 32'd0));
    send_word(make_word(ACT_EXEC, OP_IF, 10'd0, 8'd1, CMP_LT, 10'd3, 32'd0));
  endtask

  task automatic test_random_programs();
    repeat (RANDOM_PHASES) begin
      write_plen(choose_plen());
      repeat (PHASE_WORDS) send_word(gen_random_word());
    end
  endtask

  task automatic test_backpressure();
    write_plen(choose_plen());
    no_gaps = 1'b1;
    hold_off_req = 1'b1;
    repeat (40) send_word(gen_random_word());
    no_gaps = 1'b0;
    // sender pauses until the block has drained
    wait_idle(0);
    repeat (20) send_word(gen_random_word());
  endtask

  task automatic test_run_off_end();
    write_plen(PROG_DEPTH);
    send_word(make_word(ACT_EXEC, OP_JUMP, 10'd0, 8'd0, 8'd0, 10'd0, 32'd0));
    send_word(make_word(ACT_EXEC, OP_NONE_LOW, 10'd0, 8'd0, 8'd0, 10'd0, 32'd0));
    send_word(make_word(ACT_EXEC, OP_READ, 10'd7, 8'd0, 8'd0, 10'd0, 32'd99));
    send_word(make_word(ACT_LOAD, OP_NONE_LOW, 10'd7, 8'd0, 8'd0, 10'd0, 32'd42));
    write_plen(0);
    send_word(make_word(ACT_EXEC, OP_PRINT, 10'd7, 8'd0, 8'd0, 10'd0, 32'd0));
  endtask

  initial begin
    error_count  = 0;
    cycle_count  = 0;
    burst_left   = 0;
    no_gaps      = 1'b0;
    hold_off_req = 1'b0;
    idx_model    = '0;
    plen_model   = '0;
    for (int i = 0; i < MEM_DEPTH; i++) begin
      mem_model[i]   = '0;
      written_map[i] = 1'b0;
    end
    rst_n                  <= 1'b0;
    psel                   <= 1'b0;
    penable                <= 1'b0;
    pwrite                 <= 1'b0;
    paddr                  <= '0;
    pwdata                 <= '0;
    in_word_if.valid       <= 1'b0;
    in_word_if.action      <= ACT_EXEC;
    in_word_if.opcode      <= '0;
    in_word_if.param_zero  <= '0;
    in_word_if.param_one   <= '0;
    in_word_if.param_two   <= '0;
    in_word_if.param_three <= '0;
    in_word_if.data_value  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_already_done();
    test_load_and_arith();
    test_branches();
    test_random_programs();
    test_backpressure();
    test_run_off_end();
    wait_idle(SETTLE_CYCLES);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
